// ===== rtl/tfhp_pkg.sv =====
// Shared types, register indexes, event codes and constants of the frame header parser.
package tfhp_pkg;

  // Longest remaining-length field, in bytes.
  localparam logic [2:0]  LEN_BYTES_MAX = 3'd4;
  // Largest protocol name length that a sync header may declare.
  localparam logic [15:0] NAME_MAX_SIZE = 16'd8;
  // Fixed part of a sync header in bytes, excluding nothing of the name.
  localparam logic [27:0] SYNC_HDR_LEN  = 28'd12;
  // Number of bytes held in the expected name register.
  localparam logic [3:0]  NAME_BYTES    = 4'd8;

  // Configuration register indexes.
  localparam logic [3:0] REG_CONNACK_TYPE    = 4'd0;
  localparam logic [3:0] REG_DISCONNECT_TYPE = 4'd1;
  localparam logic [3:0] REG_PINGRESP_TYPE   = 4'd2;
  localparam logic [3:0] REG_SYNC_TYPE       = 4'd3;
  localparam logic [3:0] REG_EXP_NAME        = 4'd4;
  localparam logic [3:0] REG_EXP_NAME_LEN    = 4'd5;
  localparam logic [3:0] REG_EXP_VERSION     = 4'd6;
  localparam logic [3:0] REG_SYNC_MASK       = 4'd7;

  // Event codes.
  localparam logic [2:0] EV_CONNACK    = 3'd0;
  localparam logic [2:0] EV_DISCONNECT = 3'd1;
  localparam logic [2:0] EV_PINGRESP   = 3'd2;
  localparam logic [2:0] EV_SYNC       = 3'd3;
  localparam logic [2:0] EV_OTHER      = 3'd4;
  localparam logic [2:0] EV_ERROR      = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic [3:0]  connack_type;
    logic [3:0]  disconnect_type;
    logic [3:0]  pingresp_type;
    logic [3:0]  sync_type;
    logic [63:0] expected_name;
    logic [3:0]  expected_name_length;
    logic [7:0]  expected_version;
    logic [7:0]  sync_bit_mask;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [3:0]  frame_kind;
    logic [7:0]  status_byte;
    logic [15:0] message_id;
    logic [7:0]  sync_flags;
    logic [27:0] body_length;
  } result_t;

endpackage

// ===== rtl/tfhp_cfg_regs.sv =====
// Configuration register file of the frame header parser.
module tfhp_cfg_regs
  import tfhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [3:0]  wr_index,
  input  logic [63:0] wr_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.connack_type         <= 4'd2;
      cfg.disconnect_type      <= 4'd14;
      cfg.pingresp_type        <= 4'd13;
      cfg.sync_type            <= 4'd15;
      cfg.expected_name        <= '0;
      cfg.expected_name_length <= '0;
      cfg.expected_version     <= 8'd1;
      cfg.sync_bit_mask        <= 8'd1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CONNACK_TYPE:    cfg.connack_type         <= wr_data[3:0];
        REG_DISCONNECT_TYPE: cfg.disconnect_type      <= wr_data[3:0];
        REG_PINGRESP_TYPE:   cfg.pingresp_type        <= wr_data[3:0];
        REG_SYNC_TYPE:       cfg.sync_type            <= wr_data[3:0];
        REG_EXP_NAME:        cfg.expected_name        <= wr_data;
        REG_EXP_NAME_LEN:    cfg.expected_name_length <= wr_data[3:0];
        REG_EXP_VERSION:     cfg.expected_version     <= wr_data[7:0];
        REG_SYNC_MASK:       cfg.sync_bit_mask        <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/tcp_frame_header_parser_core.sv =====
// Frame header parser: type nibble, remaining length, payload count, sync header check.
// Throughput: one byte per cycle unless the skid is full; each byte updates the frame state.
// Each frame's event is registered in the output register or, on a stall, the skid entry.
// A two-entry result buffer (output register plus skid) lets bytes flow while a result waits.
// Reset (synchronous, active high) loads default type codes and clears frame and error state.
// After an error event the block keeps taking bytes but emits nothing until the next reset.
module tcp_frame_header_parser_core
  import tfhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Byte input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  // Event output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_kind,
  output logic [3:0]  frame_kind,
  output logic [7:0]  status_byte,
  output logic [15:0] message_id,
  output logic [7:0]  sync_flags,
  output logic [27:0] body_length,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t cfg;

  // The register file takes a write in every cycle.
  assign cfg_ready = 1'b1;

  tfhp_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Frame state.
  phase_t      phase, phase_next;
  logic [3:0]  frame_code, frame_code_next;
  logic [27:0] frame_length, frame_length_next;
  logic [2:0]  length_byte_count, length_byte_count_next;
  logic [27:0] payload_count, payload_count_next;
  logic [7:0]  second_byte, second_byte_next;
  logic [15:0] declared_name_length, declared_name_length_next;
  logic        header_ok, header_ok_next;
  logic [15:0] id_word, id_word_next;
  logic [7:0]  flags_byte, flags_byte_next;
  logic        error_stuck;

  // Result buffer: the output register and a skid entry behind it.
  result_t result, skid;
  logic    skid_valid;

  logic    accept;
  logic    step;
  logic    frame_done;
  logic    step_error;
  logic    sync_error;
  logic    emit;
  result_t res;

  // Helper terms of the payload path.
  logic [27:0] shifted;
  logic [27:0] pm2;
  logic [28:0] rel_full;
  logic [27:0] rel;
  logic        in_header;
  logic        rel_hit;
  logic [3:0]  name_len;
  logic        name_hit;
  logic [7:0]  name_byte;
  logic [15:0] dnl_p1;

  // The skid entry is the only reason to hold off the byte source, and it is registered.
  assign in_stall = skid_valid;
  assign accept   = in_valid & ~in_stall;
  assign step     = accept & ~error_stuck;

  assign name_len = (cfg.expected_name_length > NAME_BYTES) ? NAME_BYTES
                                                            : cfg.expected_name_length;

  // Payload offsets relative to the start of the name and to the version byte.
  assign in_header = (payload_count >= 28'd2);
  assign pm2       = payload_count - 28'd2;
  assign rel_full  = {1'b0, pm2} - {13'd0, declared_name_length};
  assign rel       = rel_full[27:0];
  assign rel_hit   = in_header & ~rel_full[28];
  assign name_hit  = in_header & (pm2 < {24'd0, name_len});
  assign name_byte = cfg.expected_name[{pm2[2:0], 3'b000} +: 8];
  assign dnl_p1    = {declared_name_length[15:8], in_byte};

  always_comb begin
    unique case (length_byte_count[1:0])
      2'd0:    shifted = {21'd0, in_byte[6:0]};
      2'd1:    shifted = {14'd0, in_byte[6:0], 7'd0};
      2'd2:    shifted = {7'd0, in_byte[6:0], 14'd0};
      default: shifted = {in_byte[6:0], 21'd0};
    endcase
  end

  // Datapath: next values of the frame fields and the end-of-frame and error conditions.
  always_comb begin
    frame_code_next           = frame_code;
    frame_length_next         = frame_length;
    length_byte_count_next    = length_byte_count;
    payload_count_next        = payload_count;
    second_byte_next          = second_byte;
    declared_name_length_next = declared_name_length;
    header_ok_next            = header_ok;
    id_word_next              = id_word;
    flags_byte_next           = flags_byte;
    frame_done                = 1'b0;
    step_error                = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        // A new frame starts: everything but the type nibble goes back to its clear value.
        frame_code_next           = in_byte[7:4];
        frame_length_next         = '0;
        length_byte_count_next    = '0;
        payload_count_next        = '0;
        second_byte_next          = '0;
        declared_name_length_next = '0;
        header_ok_next            = 1'b1;
        id_word_next              = '0;
        flags_byte_next           = '0;
      end
      PH_LENGTH: begin
        frame_length_next      = frame_length + shifted;
        length_byte_count_next = length_byte_count + 3'd1;
        if (in_byte[7]) begin
          step_error = (length_byte_count_next >= LEN_BYTES_MAX);
        end else begin
          frame_done = (frame_length_next == 28'd0);
        end
      end
      default: begin
        if (payload_count == 28'd0) begin
          declared_name_length_next = {in_byte, 8'd0};
        end
        if (payload_count == 28'd1) begin
          second_byte_next          = in_byte;
          declared_name_length_next = dnl_p1;
          if (dnl_p1 > NAME_MAX_SIZE) begin
            header_ok_next = 1'b0;
          end
        end
        if (name_hit && (name_byte != in_byte)) begin
          header_ok_next = 1'b0;
        end
        // Version, message id and flags follow the name.
        if (rel_hit) begin
          case (rel)
            28'd0:   if (in_byte != cfg.expected_version) header_ok_next = 1'b0;
            28'd1:   id_word_next = {in_byte, id_word[7:0]};
            28'd2:   id_word_next = {id_word[15:8], in_byte};
            28'd3:   flags_byte_next = in_byte;
            default: ;
          endcase
        end
        payload_count_next = payload_count + 28'd1;
        frame_done         = (payload_count_next == frame_length);
      end
    endcase
  end

  // A sync frame whose header was short or malformed ends in an error event.
  assign sync_error = (frame_length_next < SYNC_HDR_LEN) ||
                      (frame_length_next < ({12'd0, declared_name_length_next} + 28'd6)) ||
                      ~header_ok_next;

  // Event built from the frame fields after this byte's update.
  always_comb begin
    res            = '0;
    res.frame_kind = frame_code;
    if (step_error) begin
      res.event_kind = EV_ERROR;
    end else if (frame_code == cfg.connack_type) begin
      res.event_kind  = EV_CONNACK;
      res.status_byte = second_byte_next;
    end else if (frame_code == cfg.disconnect_type) begin
      res.event_kind  = EV_DISCONNECT;
      res.status_byte = second_byte_next;
    end else if (frame_code == cfg.pingresp_type) begin
      res.event_kind = EV_PINGRESP;
    end else if (frame_code == cfg.sync_type) begin
      if (sync_error) begin
        res.event_kind = EV_ERROR;
      end else if ((flags_byte_next & cfg.sync_bit_mask) != 8'd0) begin
        res.event_kind  = EV_SYNC;
        res.message_id  = id_word_next;
        res.sync_flags  = flags_byte_next;
        res.body_length = frame_length_next - SYNC_HDR_LEN;
      end else begin
        res.event_kind = EV_OTHER;
      end
    end else begin
      res.event_kind = EV_OTHER;
    end
  end

  assign emit = step & (frame_done | step_error);

  // Phase sequencing.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE:    phase_next = PH_LENGTH;
      PH_LENGTH: begin
        if (!in_byte[7]) begin
          phase_next = frame_done ? PH_IDLE : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (frame_done) begin
          phase_next = PH_IDLE;
        end
      end
      default:    phase_next = PH_IDLE;
    endcase
  end

  // Frame state registers; nothing moves once an error has been reported.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_IDLE;
      frame_code           <= '0;
      frame_length         <= '0;
      length_byte_count    <= '0;
      payload_count        <= '0;
      second_byte          <= '0;
      declared_name_length <= '0;
      header_ok            <= 1'b1;
      id_word              <= '0;
      flags_byte           <= '0;
      error_stuck          <= 1'b0;
    end else if (step) begin
      phase                <= phase_next;
      frame_code           <= frame_code_next;
      frame_length         <= frame_length_next;
      length_byte_count    <= length_byte_count_next;
      payload_count        <= payload_count_next;
      second_byte          <= second_byte_next;
      declared_name_length <= declared_name_length_next;
      header_ok            <= header_ok_next;
      id_word              <= id_word_next;
      flags_byte           <= flags_byte_next;
      if (emit && (res.event_kind == EV_ERROR)) begin
        error_stuck <= 1'b1;
      end
    end
  end

  // Result buffer control. A new event goes to the output register when that register is
  // empty or being taken, and to the skid entry otherwise. While the skid entry is full no
  // byte is taken, so no event can arrive while the skid drains into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= emit;
      end
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      result <= skid_valid ? skid : res;
    end else if (emit) begin
      skid <= res;
    end
  end

  assign event_kind  = result.event_kind;
  assign frame_kind  = result.frame_kind;
  assign status_byte = result.status_byte;
  assign message_id  = result.message_id;
  assign sync_flags  = result.sync_flags;
  assign body_length = result.body_length;

  // The skid entry only fills behind a result that is still waiting.
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds an event while the output register is empty");

  // Once an error is reported the block stays silent until reset.
  a_error_sticky : assert property (@(posedge clk) disable iff (rst)
    error_stuck |=> (error_stuck && !(emit && step)))
    else $error("error state cleared or event produced after an error");

  // Payload counting only happens for frames with a nonzero length.
  a_payload_len : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (frame_length != 28'd0))
    else $error("payload phase entered with zero frame length");

  // An emitted event that is not consumed stays put.
  a_no_loss : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && skid_valid) |=> (out_valid && skid_valid))
    else $error("buffered event dropped while output is stalled");

endmodule
